// ===== rtl/boot_command_responder_defines.svh =====
// ----------------------------------------------------------------------------
// Boot command responder assertion macros
// Shared concurrent assertion forms, clocked on clk_i and reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef BOOT_COMMAND_RESPONDER_DEFINES_SVH
`define BOOT_COMMAND_RESPONDER_DEFINES_SVH

// same-cycle implication
`define BCR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bcr_pkg.sv =====
// ----------------------------------------------------------------------------
// bcr_pkg
// Types, codes and the CRC byte step shared by the responder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcr_pkg;

  localparam int unsigned NumBytes = 8;

  localparam logic OP_TICK = 1'b0;

  localparam logic [3:0] CMD_ECHO = 4'd0;
  localparam logic [3:0] CMD_CRC  = 4'd6;

  localparam logic [7:0] RPT_ECHO = 8'd0;
  localparam logic [7:0] RPT_CRC  = 8'd5;
  localparam logic [7:0] RPT_ERR  = 8'd6;

  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [2:0] REG_WDOG    = 3'd0;
  localparam logic [2:0] REG_VERSION = 3'd1;
  localparam logic [2:0] REG_SHORT   = 3'd2;
  localparam logic [2:0] REG_LONG    = 3'd3;
  localparam logic [2:0] REG_BLINK   = 3'd4;

  localparam logic [23:0] VERSION_RST = 24'h636363;
  localparam logic [15:0] SHORT_RST   = 16'd1000;
  localparam logic [15:0] LONG_RST    = 16'd10000;
  localparam logic [7:0]  BLINK_RST   = 8'd100;

  typedef struct packed {
    logic       take;
    logic       crc_step;
    logic [2:0] crc_idx;
    logic       emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_crc;
    logic out_busy;
  } dp_status_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] acc_in,
                                           input logic [7:0]  data);
    logic [15:0] acc;
    acc = acc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CRC_POLY;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

endpackage

// ===== rtl/bcr_ctrl.sv =====
// ----------------------------------------------------------------------------
// bcr_ctrl
// Sequencer: takes a beat, walks the CRC over the stored bytes for a CRC command, then emits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                out_stall_i,
  input  bcr_pkg::dp_status_t status_i,
  output bcr_pkg::ctrl_cmd_t  cmd_o
);
  import bcr_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CRC  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic       take;
  logic       emit;

  assign in_stall_o = (state_q != ST_IDLE);
  assign take       = in_valid_i && (state_q == ST_IDLE);
  assign emit       = (state_q == ST_EMIT) && (!status_i.out_busy || !out_stall_i);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          cnt_d   = '0;
          state_d = status_i.need_crc ? ST_CRC : ST_EMIT;
        end
      end
      ST_CRC: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'(NumBytes - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    cmd_o.take     = take;
    cmd_o.crc_step = (state_q == ST_CRC);
    cmd_o.crc_idx  = cnt_q;
    cmd_o.emit     = emit;
  end

endmodule

// ===== rtl/bcr_dp.sv =====
// ----------------------------------------------------------------------------
// bcr_dp
// Register file, message store, timers, CRC accumulator and output beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcr_dp #(
  parameter int unsigned PayloadBytes = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                opcode_i,
  input  logic [3:0]          cmd_id_i,
  input  logic [3:0]          payload_len_i,
  input  logic [63:0]         payload_i,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  input  logic                out_stall_i,
  input  bcr_pkg::ctrl_cmd_t  cmd_i,
  output bcr_pkg::dp_status_t status_o,
  output logic                out_valid_o,
  output logic                report_valid_o,
  output logic [63:0]         report_payload_o,
  output logic                red_led_o,
  output logic                halted_o
);
  import bcr_pkg::*;

  localparam logic [3:0] LenMax = 4'(PayloadBytes);

  logic        wdog_q;
  logic [23:0] version_q;
  logic [15:0] short_q, long_q;
  logic [7:0]  blink_rld_q;

  logic [7:0]  msg_q [NumBytes];
  logic [7:0]  msg_d [NumBytes];
  logic [7:0]  rx_q, rx_d;
  logic [15:0] time_left_q, time_left_d;
  logic        armed_q, armed_d;
  logic [7:0]  blink_q, blink_d;
  logic        led_q, led_d;
  logic        stopped_q, stopped_d;
  logic        rpt_q, rpt_d;
  logic [3:0]  cmd_q, cmd_d;
  logic [15:0] crc_q, crc_d;

  logic        out_valid_q;
  logic        rv_q, led_out_q, halted_q;
  logic [63:0] payload_q;

  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [15:0] tl_cur;
  logic [3:0]  len_eff;
  logic [7:0]  rtype, b5, b6;
  logic [63:0] report;

  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wdog_q      <= 1'b0;
      version_q   <= VERSION_RST;
      short_q     <= SHORT_RST;
      long_q      <= LONG_RST;
      blink_rld_q <= BLINK_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_WDOG:    wdog_q      <= pwdata[0];
        REG_VERSION: version_q   <= pwdata[23:0];
        REG_SHORT:   short_q     <= pwdata[15:0];
        REG_LONG:    long_q      <= pwdata[15:0];
        REG_BLINK:   blink_rld_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WDOG:    prdata = {31'd0, wdog_q};
      REG_VERSION: prdata = {8'd0, version_q};
      REG_SHORT:   prdata = {16'd0, short_q};
      REG_LONG:    prdata = {16'd0, long_q};
      REG_BLINK:   prdata = {24'd0, blink_rld_q};
      default:     prdata = '0;
    endcase
  end

  assign tl_cur  = armed_q ? time_left_q : (wdog_q ? long_q : short_q);
  assign len_eff = (payload_len_i > LenMax) ? LenMax : payload_len_i;

  always_comb begin
    msg_d       = msg_q;
    rx_d        = rx_q;
    time_left_d = time_left_q;
    armed_d     = armed_q;
    blink_d     = blink_q;
    led_d       = led_q;
    stopped_d   = stopped_q;
    rpt_d       = rpt_q;
    cmd_d       = cmd_q;
    crc_d       = crc_q;
    if (cmd_i.take) begin
      rpt_d = 1'b0;
      cmd_d = cmd_id_i;
      crc_d = '0;
      if (!stopped_q) begin
        armed_d     = 1'b1;
        time_left_d = tl_cur;
        if (opcode_i == OP_TICK) begin
          if (blink_q == 8'd0) begin
            blink_d = blink_rld_q;
            led_d   = ~led_q;
          end else begin
            blink_d = blink_q - 8'd1;
          end
          if (tl_cur == 16'd0) begin
            stopped_d = 1'b1;
          end else begin
            time_left_d = tl_cur - 16'd1;
          end
        end else begin
          for (int i = 0; i < NumBytes; i++) begin
            if (4'(i) < len_eff) begin
              msg_d[i] = payload_i[8*i +: 8];
            end
          end
          rx_d        = rx_q + 8'd1;
          time_left_d = long_q;
          rpt_d       = 1'b1;
        end
      end
    end
    if (cmd_i.crc_step) begin
      crc_d = crc_byte(crc_q, msg_q[cmd_i.crc_idx]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumBytes; i++) begin
        msg_q[i] <= '0;
      end
      rx_q        <= '0;
      time_left_q <= '0;
      armed_q     <= 1'b0;
      blink_q     <= BLINK_RST;
      led_q       <= 1'b1;
      stopped_q   <= 1'b0;
      rpt_q       <= 1'b0;
    end else begin
      msg_q       <= msg_d;
      rx_q        <= rx_d;
      time_left_q <= time_left_d;
      armed_q     <= armed_d;
      blink_q     <= blink_d;
      led_q       <= led_d;
      stopped_q   <= stopped_d;
      rpt_q       <= rpt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    crc_q <= crc_d;
  end

  always_comb begin
    if (cmd_q == CMD_ECHO) begin
      rtype = RPT_ECHO;
      b5    = '0;
      b6    = '0;
    end else if (cmd_q == CMD_CRC) begin
      rtype = RPT_CRC;
      b5    = crc_q[15:8];
      b6    = crc_q[7:0];
    end else begin
      rtype = RPT_ERR;
      b5    = {4'd0, cmd_q};
      b6    = '0;
    end
    report = {rx_q, b6, b5, rtype, 8'd1,
              version_q[7:0], version_q[15:8], version_q[23:16]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rv_q        <= 1'b0;
      led_out_q   <= 1'b1;
      halted_q    <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        rv_q        <= rpt_q;
        led_out_q   <= led_q;
        halted_q    <= stopped_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      payload_q <= rpt_q ? report : '0;
    end
  end

  assign status_o.need_crc = (opcode_i != OP_TICK) && (cmd_id_i == CMD_CRC) && !stopped_q;
  assign status_o.out_busy = out_valid_q;

  assign out_valid_o      = out_valid_q;
  assign report_valid_o   = rv_q;
  assign report_payload_o = payload_q;
  assign red_led_o        = led_out_q;
  assign halted_o         = halted_q;

endmodule

// ===== rtl/boot_command_responder.sv =====
// ----------------------------------------------------------------------------
// boot_command_responder
// Boot command responder with LED blink and idle-timeout supervisor.
//
// Input channel (in_valid_i / in_stall_o) carries one beat per item: a 1 ms
// tick (opcode 0) or a received command message (opcode 1). Output channel
// (out_valid_o / out_stall_i) returns exactly one beat per item with the
// report, the LED level and the halted flag after that item.
// A tick or a ping/unknown message passes from accept to the EMIT state and
// then into the output register; a CRC test first walks the CRC state, as the
// CRC unit folds one stored byte per cycle over the eight stored bytes. The
// next item is accepted the cycle after the result enters the output register.
// When the receiver stalls, the output beat holds; one more item may be
// accepted and carried to its emit, then in_stall_o stays high until the output frees.
// Reset clears the message store, counters and timer, sets the LED on and
// restores the register defaults. The idle timer is loaded on the first item
// after reset; once it expires, items are still answered but ignored. The user
// must write registers over the APB port while the block is idle (unchecked).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module boot_command_responder #(
  parameter int unsigned PAYLOAD_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [3:0]  cmd_id_i,
  input  logic [3:0]  payload_len_i,
  input  logic [63:0] payload_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        report_valid_o,
  output logic [63:0] report_payload_o,
  output logic        red_led_o,
  output logic        halted_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bcr_pkg::*;

  `include "boot_command_responder_defines.svh"

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign pready = 1'b1;

  bcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bcr_dp #(
    .PayloadBytes(PAYLOAD_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .opcode_i        (opcode_i),
    .cmd_id_i        (cmd_id_i),
    .payload_len_i   (payload_len_i),
    .payload_i       (payload_i),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .out_stall_i     (out_stall_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .report_valid_o  (report_valid_o),
    .report_payload_o(report_payload_o),
    .red_led_o       (red_led_o),
    .halted_o        (halted_o)
  );

  `BCR_ASSERT_NEXT(a_halt_sticky, halted_o, halted_o, "halted flag dropped")
  `BCR_ASSERT_NOW(a_no_report_halted, report_valid_o, !halted_o, "report after halt")
  `BCR_ASSERT_NEXT(a_busy_after_take, in_valid_i && !in_stall_o, in_stall_o,
                   "input taken while item in flight")
  `BCR_ASSERT_NOW(a_emit_excl, cmd.emit, !cmd.take && !cmd.crc_step,
                  "emit overlaps take or crc step")

endmodule
